/* sv/quaternion_smallest_three_unpack_core_defines.svh */
// Assertion macros for the smallest-three quaternion decoder checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef QUATERNION_SMALLEST_THREE_UNPACK_CORE_DEFINES_SVH
`define QUATERNION_SMALLEST_THREE_UNPACK_CORE_DEFINES_SVH

// same-cycle implication
`define QST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qst check failed");

// next-cycle implication
`define QST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qst check failed");

`endif

/* sv/qst_pkg.sv */
// Shared constants and types for the smallest-three quaternion decoder.
// No dependencies.
package qst_pkg;

  localparam int unsigned CODE_SPAN   = 5793;
  localparam int unsigned CODE_MAX    = 1023;
  localparam int unsigned CODE_OFFSET = 2896;
  localparam int unsigned Q12_ONE     = 4096;

  localparam int unsigned CODE_W  = 10;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned VAL_W   = 13;
  localparam int unsigned MAG_W   = 12;
  localparam int unsigned SQ_W    = 12;
  localparam int unsigned SUM_W   = 13;
  localparam int unsigned ROOT_W  = 25;
  localparam int unsigned COMP_W  = 14;

  // radicand is at most 2^24, so the root walks bit positions 24, 22 .. 0
  localparam int unsigned ROOT_STEPS = 13;
  localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [1:0]        largest;
    val_t              v0;
    val_t              v1;
    val_t              v2;
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
    logic [ROOT_W-1:0] step_bit;
  } root_item_t;

endpackage

/* sv/qst_front.sv */
// Front pipeline: code expansion, scaling by 5793/1023, squaring and radicand.
// Four register stages with per-stage valid/ready. Uses qst_pkg.
module qst_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            in_packed_high,
  input  logic [15:0]            in_packed_low,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qst_pkg::root_item_t    out_item
);

  logic                                      s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                                      rdy1, rdy2, rdy3, rdy4;
  logic [1:0]                                s1_largest_r, s2_largest_r, s3_largest_r;
  logic [2:0][qst_pkg::PROD_W-1:0]           s1_prod_r;
  logic [2:0][qst_pkg::CODE_W-1:0]           codes;
  qst_pkg::val_t                             s2_val_r [3];
  qst_pkg::val_t                             s3_val_r [3];
  logic [2:0][qst_pkg::SQ_W-1:0]             s3_sq_r;
  logic [2:0][qst_pkg::PROD_W:0]             est_sum;
  logic [2:0][qst_pkg::VAL_W-1:0]            est;
  logic [2:0][qst_pkg::PROD_W:0]             rem;
  logic [2:0][qst_pkg::VAL_W-1:0]            quot;
  logic [2:0][qst_pkg::VAL_W-1:0]            neg;
  logic [2:0][qst_pkg::MAG_W-1:0]            mag;
  logic [qst_pkg::SUM_W-1:0]                 sq_sum;
  logic [qst_pkg::SUM_W-1:0]                 rad;
  qst_pkg::root_item_t                       s4_item_r;

  assign rdy4     = !s4_v_r || out_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  assign codes[0] = in_packed_high[13:4];
  assign codes[1] = {in_packed_high[3:0], in_packed_low[15:10]};
  assign codes[2] = in_packed_low[9:0];

  // floor(p/1023): underestimate by (p + p>>10)>>10, then one correction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      est_sum[i] = {1'b0, s1_prod_r[i]} + (qst_pkg::PROD_W+1)'(s1_prod_r[i][qst_pkg::PROD_W-1:10]);
      est[i]     = est_sum[i][qst_pkg::PROD_W-1:10];
      rem[i]     = {1'b0, s1_prod_r[i]} + (qst_pkg::PROD_W+1)'(est[i])
                   - (qst_pkg::PROD_W+1)'({est[i], 10'b0});
      quot[i]    = (rem[i] >= (qst_pkg::PROD_W+1)'(qst_pkg::CODE_MAX)) ? est[i] + 1'b1 : est[i];
      neg[i]     = -s2_val_r[i];
      mag[i]     = s2_val_r[i][qst_pkg::VAL_W-1] ? neg[i][qst_pkg::MAG_W-1:0]
                                                 : s2_val_r[i][qst_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    sq_sum = qst_pkg::SUM_W'(s3_sq_r[0]) + qst_pkg::SUM_W'(s3_sq_r[1])
           + qst_pkg::SUM_W'(s3_sq_r[2]);
    if (sq_sum >= qst_pkg::SUM_W'(qst_pkg::Q12_ONE)) begin
      rad = '0;
    end else begin
      rad = qst_pkg::SUM_W'(qst_pkg::Q12_ONE) - sq_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_largest_r <= in_packed_high[15:14];
      for (int i = 0; i < 3; i++) begin
        s1_prod_r[i] <= qst_pkg::PROD_W'(codes[i]) * qst_pkg::PROD_W'(qst_pkg::CODE_SPAN);
      end
    end
    if (s1_v_r && rdy2) begin
      s2_largest_r <= s1_largest_r;
      for (int i = 0; i < 3; i++) begin
        s2_val_r[i] <= quot[i] - qst_pkg::VAL_W'(qst_pkg::CODE_OFFSET);
      end
    end
    if (s2_v_r && rdy3) begin
      s3_largest_r <= s2_largest_r;
      for (int i = 0; i < 3; i++) begin
        s3_val_r[i] <= s2_val_r[i];
        s3_sq_r[i]  <= qst_pkg::SQ_W'((24'(mag[i]) * 24'(mag[i])) >> 12);
      end
    end
    if (s3_v_r && rdy4) begin
      s4_item_r.largest  <= s3_largest_r;
      s4_item_r.v0       <= s3_val_r[0];
      s4_item_r.v1       <= s3_val_r[1];
      s4_item_r.v2       <= s3_val_r[2];
      s4_item_r.rem      <= {rad, 12'b0};
      s4_item_r.res      <= '0;
      s4_item_r.step_bit <= qst_pkg::ROOT_BIT0;
    end
  end

  assign out_valid = s4_v_r;
  assign out_item  = s4_item_r;

endmodule

/* sv/qst_root_cell.sv */
// One step of the digit-by-digit square root, with its own item register.
// Carries the decoded components alongside. Uses qst_pkg.
module qst_root_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  qst_pkg::root_item_t    in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qst_pkg::root_item_t    out_item
);

  logic                        v_r;
  qst_pkg::root_item_t         item_r;
  qst_pkg::root_item_t         item_nxt;
  logic [qst_pkg::ROOT_W:0]    trial;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    item_nxt = in_item;
    trial    = {1'b0, in_item.res} + {1'b0, in_item.step_bit};
    if ({1'b0, in_item.rem} >= trial) begin
      item_nxt.rem = in_item.rem - trial[qst_pkg::ROOT_W-1:0];
      item_nxt.res = (in_item.res >> 1) + in_item.step_bit;
    end else begin
      item_nxt.res = in_item.res >> 1;
    end
    item_nxt.step_bit = in_item.step_bit >> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

/* sv/quaternion_smallest_three_unpack_core.sv */
// Smallest-three quaternion decoder: one 32-bit packed word in, four Q12 components out.
// Accepts one item every cycle unless output stalls back up the pipeline; each item
// passes through four front stages (scale, divide, square, radicand) and a chain of 13
// square-root cells, one cell per root bit. Every register stage has its own valid and
// ready, so an empty stage takes the next item even while the output waits.
// Depends on qst_pkg, qst_front and qst_root_cell.
module quaternion_smallest_three_unpack_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [15:0]                         in_packed_high,
  input  logic [15:0]                         in_packed_low,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qst_pkg::COMP_W-1:0]   out_comp0,
  output logic signed [qst_pkg::COMP_W-1:0]   out_comp1,
  output logic signed [qst_pkg::COMP_W-1:0]   out_comp2,
  output logic signed [qst_pkg::COMP_W-1:0]   out_comp3
);

  logic [qst_pkg::ROOT_STEPS:0]               chain_v;
  logic [qst_pkg::ROOT_STEPS:0]               chain_rdy;
  qst_pkg::root_item_t                        chain_item [qst_pkg::ROOT_STEPS+1];
  qst_pkg::root_item_t                        last;
  logic [3:0][qst_pkg::COMP_W-1:0]            comp;
  logic [1:0]                                 slot_off;

  qst_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packed_high (in_packed_high),
    .in_packed_low  (in_packed_low),
    .out_valid      (chain_v[0]),
    .out_ready      (chain_rdy[0]),
    .out_item       (chain_item[0])
  );

  for (genvar g = 0; g < qst_pkg::ROOT_STEPS; g++) begin : g_root
    qst_root_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[g]),
      .in_ready  (chain_rdy[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_v[g+1]),
      .out_ready (chain_rdy[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  assign last                            = chain_item[qst_pkg::ROOT_STEPS];
  assign out_valid                       = chain_v[qst_pkg::ROOT_STEPS];
  assign chain_rdy[qst_pkg::ROOT_STEPS]  = out_ready;

  // slot s gets the root when s == largest, else code (s - largest - 1)
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      slot_off = 2'(s) - last.largest;
      case (slot_off)
        2'd0:    comp[s] = {1'b0, last.res[qst_pkg::COMP_W-2:0]};
        2'd1:    comp[s] = {last.v0[qst_pkg::VAL_W-1], last.v0};
        2'd2:    comp[s] = {last.v1[qst_pkg::VAL_W-1], last.v1};
        default: comp[s] = {last.v2[qst_pkg::VAL_W-1], last.v2};
      endcase
    end
  end

  assign out_comp0 = comp[0];
  assign out_comp1 = comp[1];
  assign out_comp2 = comp[2];
  assign out_comp3 = comp[3];

endmodule

/* sv/qst_checker.sv */
// Port-level checks for the smallest-three quaternion decoder, bound to the top level.
// Uses the assertion macros header and qst_pkg.
`include "quaternion_smallest_three_unpack_core_defines.svh"

module qst_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [15:0]                         in_packed_high,
  input logic [15:0]                         in_packed_low,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [qst_pkg::COMP_W-1:0]   out_comp0,
  input logic signed [qst_pkg::COMP_W-1:0]   out_comp1,
  input logic signed [qst_pkg::COMP_W-1:0]   out_comp2,
  input logic signed [qst_pkg::COMP_W-1:0]   out_comp3
);

  logic in_seen;
  logic comps_in_range;

  assign in_seen = in_valid && (in_packed_high == in_packed_high) && (in_packed_low == in_packed_low);

  assign comps_in_range =
    (out_comp0 >= -14'sd2896) && (out_comp0 <= 14'sd4096) &&
    (out_comp1 >= -14'sd2896) && (out_comp1 <= 14'sd4096) &&
    (out_comp2 >= -14'sd2896) && (out_comp2 <= 14'sd4096) &&
    (out_comp3 >= -14'sd2896) && (out_comp3 <= 14'sd4096);

  `QST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_comp0) && $stable(out_comp1) && $stable(out_comp2) && $stable(out_comp3))
  `QST_ASSERT_NOW(a_drain_ready, out_ready || !out_valid || in_seen, in_ready || !out_ready)
  `QST_ASSERT_NOW(a_range, out_valid, comps_in_range)
  `QST_ASSERT_NOW(a_root_nonneg, out_valid, !out_comp0[13] || !out_comp1[13] || !out_comp2[13] || !out_comp3[13])

endmodule

bind quaternion_smallest_three_unpack_core qst_checker u_qst_checker (.*);

/* tb/quat_decode_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the smallest-three quaternion decoder: watches both channels, predicts the
// four Q12 components of every accepted item and compares them in order with the results.
// Depends on qst_pkg.
module quat_decode_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [15:0]                       in_packed_high,
  input  logic [15:0]                       in_packed_low,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [qst_pkg::COMP_W-1:0] out_comp0,
  input  logic signed [qst_pkg::COMP_W-1:0] out_comp1,
  input  logic signed [qst_pkg::COMP_W-1:0] out_comp2,
  input  logic signed [qst_pkg::COMP_W-1:0] out_comp3,
  output int                                mismatch_count,
  output int                                quats_in_flight
);

  typedef logic signed [qst_pkg::COMP_W-1:0] comp_t;
  typedef struct packed {
    comp_t q0;
    comp_t q1;
    comp_t q2;
    comp_t q3;
  } quat_t;

  quat_t expected_quats[$];
  quat_t want;

  function automatic int code_value(logic [9:0] code);
    return int'((int'(code) * qst_pkg::CODE_SPAN) / qst_pkg::CODE_MAX)
           - int'(qst_pkg::CODE_OFFSET);
  endfunction

  function automatic int q12_square(int v);
    int mag;
    mag = (v < 0) ? -v : v;
    return (mag * mag) >>> 12;
  endfunction

  // bitwise floor square root, result fits in 13 bits
  function automatic int q12_root(int x);
    int r;
    int trial;
    r = 0;
    for (int b = 12; b >= 0; b--) begin
      trial = r | (1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  function automatic quat_t decode_quat(logic [15:0] hi, logic [15:0] lo);
    logic [1:0] big;
    logic [1:0] idx;
    int         vals [3];
    comp_t      slot [4];
    int         sum;
    int         rad;
    quat_t      q;
    big     = hi[15:14];
    vals[0] = code_value(hi[13:4]);
    vals[1] = code_value({hi[3:0], lo[15:10]});
    vals[2] = code_value(lo[9:0]);
    sum     = 0;
    for (int k = 0; k < 3; k++) begin
      idx       = big + 2'(k + 1);
      slot[idx] = comp_t'(vals[k]);
      sum      += q12_square(vals[k]);
    end
    // squares past one: clamp the radicand
    rad       = (sum >= int'(qst_pkg::Q12_ONE)) ? 0 : int'(qst_pkg::Q12_ONE) - sum;
    slot[big] = comp_t'(q12_root(rad * int'(qst_pkg::Q12_ONE)));
    q.q0 = slot[0];
    q.q1 = slot[1];
    q.q2 = slot[2];
    q.q3 = slot[3];
    return q;
  endfunction

  task automatic check_comp(string label, comp_t exp_v, comp_t got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_quats.push_back(decode_quat(in_packed_high, in_packed_low));
      end
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          $display("%0t ns: result with no item outstanding, expected none, actual %0d %0d %0d %0d",
                   $time, out_comp0, out_comp1, out_comp2, out_comp3);
          mismatch_count++;
        end else begin
          want = expected_quats.pop_front();
          check_comp("comp0", want.q0, out_comp0);
          check_comp("comp1", want.q1, out_comp1);
          check_comp("comp2", want.q2, out_comp2);
          check_comp("comp3", want.q3, out_comp3);
        end
      end
      quats_in_flight = expected_quats.size();
    end
  end

endmodule

/* tb/tb_quaternion_smallest_three_unpack_core.sv */
`timescale 1ns / 100ps
// Top of the smallest-three quaternion decoder testbench: clock, reset, directed and random
// packed words, random idling on both channels and the verdict. Depends on qst_pkg,
// quat_decode_checker and quaternion_smallest_three_unpack_core.
module tb_quaternion_smallest_three_unpack_core;

  localparam int ITEM_COUNT   = 1000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 250;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [15:0]                       in_packed_high;
  logic [15:0]                       in_packed_low;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [qst_pkg::COMP_W-1:0] out_comp0;
  logic signed [qst_pkg::COMP_W-1:0] out_comp1;
  logic signed [qst_pkg::COMP_W-1:0] out_comp2;
  logic signed [qst_pkg::COMP_W-1:0] out_comp3;

  int cycle_count;
  int mismatch_count;
  int quats_in_flight;
  int results_taken;
  bit sender_steady;
  bit receiver_steady;

  quaternion_smallest_three_unpack_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packed_high (in_packed_high),
    .in_packed_low  (in_packed_low),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_comp0      (out_comp0),
    .out_comp1      (out_comp1),
    .out_comp2      (out_comp2),
    .out_comp3      (out_comp3)
  );

  quat_decode_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_packed_high  (in_packed_high),
    .in_packed_low   (in_packed_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_comp0       (out_comp0),
    .out_comp1       (out_comp1),
    .out_comp2       (out_comp2),
    .out_comp3       (out_comp3),
    .mismatch_count  (mismatch_count),
    .quats_in_flight (quats_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] pack_quat(logic [1:0] big, logic [9:0] c0, logic [9:0] c1,
                                            logic [9:0] c2);
    return {big, c0, c1, c2};
  endfunction

  function automatic logic [31:0] random_word();
    int         mode;
    logic [9:0] codes [3];
    mode = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0: codes[k] = 10'($urandom_range(0, 1023));
        2: codes[k] = $urandom_range(0, 1) ? 10'($urandom_range(850, 1023))
                                           : 10'($urandom_range(0, 173));
        default: codes[k] = 10'($urandom_range(300, 724));
      endcase
    end
    return pack_quat(2'($urandom_range(0, 3)), codes[0], codes[1], codes[2]);
  endfunction

  task automatic send_word(logic [31:0] word);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_high <= word[31:16];
    in_packed_low  <= word[15:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off so the pipeline backs up
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (results_taken % 80 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
      else stall = receiver_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] directed_words[$];
    in_valid       = 1'b0;
    in_packed_high = '0;
    in_packed_low  = '0;
    out_ready      = 1'b0;
    rst_n          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int big = 0; big < 4; big++) begin
      directed_words.push_back(pack_quat(2'(big), 10'd512, 10'd512, 10'd512));
      directed_words.push_back(pack_quat(2'(big), 10'd0, 10'd0, 10'd0));
    end
    directed_words.push_back(pack_quat(2'd0, 10'd1023, 10'd1023, 10'd1023));
    // just inside and just past a radicand of zero
    directed_words.push_back(pack_quat(2'd1, 10'd929, 10'd929, 10'd929));
    directed_words.push_back(pack_quat(2'd2, 10'd930, 10'd930, 10'd930));
    directed_words.push_back(32'h0000_0000);
    directed_words.push_back(32'hFFFF_FFFF);
    directed_words.push_back(pack_quat(2'd3, 10'd0, 10'd1023, 10'd511));
    directed_words.push_back(pack_quat(2'd1, 10'd1023, 10'd0, 10'd512));
    // second code straddles the two halves
    directed_words.push_back(pack_quat(2'd2, 10'h3C0, 10'h03F, 10'h155));
    directed_words.push_back(pack_quat(2'd0, 10'h03F, 10'h3C0, 10'h2AA));
    directed_words.push_back(pack_quat(2'd3, 10'd511, 10'd511, 10'd511));
    directed_words.push_back(pack_quat(2'd0, 10'd1, 10'd1022, 10'd512));

    foreach (directed_words[i]) send_word(directed_words[i]);

    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n % 100 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    in_valid <= 1'b0;

    while (quats_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
